// ===== design/i2cms_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C master transaction sequencer package
// Word types, operation, command, status and phase codes shared by the design.
// ----------------------------------------------------------------------------
package i2cms_pkg;

	localparam logic [7:0] READ_BIT = 8'h01;

	typedef enum logic [1:0] {
		OP_BEGIN_WRITE = 2'd0,
		OP_BEGIN_READ  = 2'd1,
		OP_EVENT       = 2'd2,
		OP_COLLISION   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		CMD_NONE   = 3'd0,
		CMD_START  = 3'd1,
		CMD_TX     = 3'd2,
		CMD_RX     = 3'd3,
		CMD_ACK    = 3'd4,
		CMD_NAK    = 3'd5,
		CMD_STOP   = 3'd6,
		CMD_RSTART = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_ADDR_NAK = 3'd1,
		ST_DATA_NAK = 3'd2,
		ST_BUS      = 3'd3,
		ST_INTERNAL = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_STARTING = 3'd1,
		PH_ADDRESS  = 3'd2,
		PH_READ     = 3'd3,
		PH_READACK  = 3'd4,
		PH_READNAK  = 3'd5,
		PH_WRITE    = 3'd6,
		PH_STOP     = 3'd7
	} phase_t;

	typedef struct packed {
		op_t        op;
		logic [6:0] dev_address;
		logic [7:0] xfer_length;
		logic       end_with_stop;
		logic       start_busy;
		logic       transmit_busy;
		logic       nak_seen;
		logic       rx_full;
		logic [7:0] rx_byte;
		logic [7:0] write_byte;
	} ev_word_t;

	typedef struct packed {
		cmd_t       command;
		logic [7:0] out_byte;
		logic       store_valid;
		logic [7:0] store_index;
		logic [7:0] store_byte;
		logic [7:0] next_index;
		logic       done_res;
		status_t    status;
		logic [7:0] transferred;
		logic       rejected;
	} res_word_t;

endpackage

// ===== design/i2c_master_transaction_sequencer.sv =====
// ----------------------------------------------------------------------------
// I2C master transaction sequencer
// Stages: input register, state machine, result register.
// Throughput: one word per cycle while res_ready keeps the result register free.
// Reset: arst_n clears all control state to idle with zero counts and codes.
// ----------------------------------------------------------------------------
module i2c_master_transaction_sequencer
	import i2cms_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      ev_valid,
	output logic      ev_ready,
	input  ev_word_t  ev_word,
	output logic      res_valid,
	input  logic      res_ready,
	output res_word_t res_word
);

	logic      valid_s1;
	ev_word_t  word_s1;
	logic      advance;

	phase_t     phase_q, phase_d;
	logic [7:0] address_byte_q, address_byte_d;
	logic       stop_at_end_q, stop_at_end_d;
	logic       rs_pending_q, rs_pending_d;
	status_t    error_code_q, error_code_d;
	logic [7:0] byte_total_q, byte_total_d;
	logic [7:0] byte_index_q, byte_index_d;

	logic       is_begin;
	logic [7:0] index_inc;
	res_word_t  res_d;

	// The result register frees up when it is empty or being read this cycle.
	assign advance  = !res_valid || res_ready;
	assign ev_ready = !valid_s1 || advance;

	assign is_begin  = (word_s1.op == OP_BEGIN_WRITE) || (word_s1.op == OP_BEGIN_READ);
	assign index_inc = byte_index_q + 8'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ev_ready) begin
			valid_s1 <= ev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ev_ready && ev_valid) begin
			word_s1 <= ev_word;
		end
	end

	// Next-state logic.
	always_comb begin
		phase_d        = phase_q;
		address_byte_d = address_byte_q;
		stop_at_end_d  = stop_at_end_q;
		rs_pending_d   = rs_pending_q;
		error_code_d   = error_code_q;
		byte_total_d   = byte_total_q;
		byte_index_d   = byte_index_q;
		if (is_begin) begin
			if (phase_q == PH_IDLE) begin
				address_byte_d = {word_s1.dev_address, 1'b0}
					| ((word_s1.op == OP_BEGIN_READ) ? READ_BIT : 8'h00);
				stop_at_end_d  = word_s1.end_with_stop;
				error_code_d   = ST_OK;
				byte_total_d   = word_s1.xfer_length;
				byte_index_d   = 8'd0;
				phase_d        = rs_pending_q ? PH_ADDRESS : PH_STARTING;
			end
		end else if (word_s1.op == OP_COLLISION) begin
			phase_d      = PH_STOP;
			rs_pending_d = 1'b0;
			error_code_d = ST_BUS;
		end else begin
			case (phase_q)
				PH_STARTING: begin
					if (!word_s1.start_busy) begin
						byte_index_d = 8'd0;
						phase_d      = PH_ADDRESS;
					end else begin
						phase_d      = PH_STOP;
						rs_pending_d = 1'b0;
						error_code_d = ST_INTERNAL;
					end
				end
				PH_ADDRESS: begin
					if (word_s1.transmit_busy || word_s1.nak_seen || byte_total_q == 8'd0) begin
						phase_d      = PH_STOP;
						rs_pending_d = 1'b0;
						if (word_s1.transmit_busy) begin
							error_code_d = ST_INTERNAL;
						end else if (word_s1.nak_seen) begin
							error_code_d = ST_ADDR_NAK;
						end else begin
							error_code_d = ST_OK;
						end
					end else if (|(address_byte_q & READ_BIT)) begin
						phase_d = PH_READ;
					end else begin
						byte_index_d = 8'd1;
						phase_d      = PH_WRITE;
					end
				end
				PH_WRITE: begin
					if (word_s1.transmit_busy || word_s1.nak_seen) begin
						phase_d      = PH_STOP;
						rs_pending_d = 1'b0;
						error_code_d = word_s1.transmit_busy ? ST_INTERNAL : ST_DATA_NAK;
					end else if (byte_index_q >= byte_total_q) begin
						phase_d      = PH_STOP;
						rs_pending_d = !stop_at_end_q;
					end else begin
						byte_index_d = index_inc;
					end
				end
				PH_READ: begin
					if (word_s1.rx_full) begin
						byte_index_d = index_inc;
						phase_d      = (index_inc >= byte_total_q) ? PH_READNAK : PH_READACK;
					end else begin
						phase_d      = PH_STOP;
						rs_pending_d = 1'b0;
						error_code_d = ST_INTERNAL;
					end
				end
				PH_READACK: begin
					phase_d = PH_READ;
				end
				PH_READNAK: begin
					phase_d      = PH_STOP;
					rs_pending_d = !stop_at_end_q;
				end
				PH_STOP: begin
					phase_d = PH_IDLE;
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end
	end

	// Output logic.
	always_comb begin
		res_d            = '0;
		res_d.command    = CMD_NONE;
		res_d.status     = ST_OK;
		res_d.next_index = byte_index_d;
		if (is_begin) begin
			if (phase_q != PH_IDLE) begin
				res_d.rejected = 1'b1;
			end else if (rs_pending_q) begin
				res_d.command  = CMD_TX;
				res_d.out_byte = address_byte_d;
			end else begin
				res_d.command = CMD_START;
			end
		end else if (word_s1.op == OP_COLLISION) begin
			res_d.command = CMD_STOP;
		end else begin
			case (phase_q)
				PH_STARTING: begin
					if (!word_s1.start_busy) begin
						res_d.command  = CMD_TX;
						res_d.out_byte = address_byte_q;
					end else begin
						res_d.command = CMD_STOP;
					end
				end
				PH_ADDRESS, PH_WRITE: begin
					if (phase_d == PH_WRITE) begin
						res_d.command  = CMD_TX;
						res_d.out_byte = word_s1.write_byte;
					end else if (phase_d == PH_READ) begin
						res_d.command = CMD_RX;
					end else if (rs_pending_d) begin
						res_d.command = CMD_RSTART;
					end else begin
						res_d.command = CMD_STOP;
					end
				end
				PH_READ: begin
					if (word_s1.rx_full) begin
						res_d.store_valid = 1'b1;
						res_d.store_index = byte_index_q;
						res_d.store_byte  = word_s1.rx_byte;
						res_d.command     = (phase_d == PH_READNAK) ? CMD_NAK : CMD_ACK;
					end else begin
						res_d.command = CMD_STOP;
					end
				end
				PH_READACK: begin
					res_d.command = CMD_RX;
				end
				PH_READNAK: begin
					res_d.command = stop_at_end_q ? CMD_STOP : CMD_RSTART;
				end
				PH_STOP: begin
					res_d.done_res    = 1'b1;
					res_d.status      = error_code_q;
					res_d.transferred = (error_code_q == ST_OK) ? byte_total_q : 8'd0;
				end
				default: begin
					res_d.command = CMD_NONE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			address_byte_q <= 8'd0;
			stop_at_end_q  <= 1'b0;
			rs_pending_q   <= 1'b0;
			error_code_q   <= ST_OK;
			byte_total_q   <= 8'd0;
			byte_index_q   <= 8'd0;
			res_valid      <= 1'b0;
		end else if (advance) begin
			res_valid <= valid_s1;
			if (valid_s1) begin
				phase_q        <= phase_d;
				address_byte_q <= address_byte_d;
				stop_at_end_q  <= stop_at_end_d;
				rs_pending_q   <= rs_pending_d;
				error_code_q   <= error_code_d;
				byte_total_q   <= byte_total_d;
				byte_index_q   <= byte_index_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_word <= res_d;
		end
	end

	// A finished transaction leaves the sequencer idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && valid_s1 && res_d.done_res |=> phase_q == PH_IDLE)
		else $error("phase not idle after a completion word");

	// A refused begin must not disturb the transaction in progress.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && valid_s1 && res_d.rejected |=> $stable(phase_q) && $stable(byte_index_q))
		else $error("rejected begin changed the state");

	// A received byte is only stored together with an ack or nak command.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_word.store_valid |->
			res_word.command == CMD_ACK || res_word.command == CMD_NAK)
		else $error("store without ack or nak");

	// Error status is only reported on the completion word.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_word.status != ST_OK |-> res_word.done_res)
		else $error("status reported outside completion");

endmodule
